### sv/bdda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdda_pkg - shared types and constants
// Field widths, arithmetic constants, calendar tables and the command and
// status words between the controller and the datapath.
// ----------------------------------------------------------------------------
package bdda_pkg;

    localparam int DAY_W   = 5;
    localparam int MON_W   = 4;
    localparam int YEAR_W  = 14;
    localparam int LEAVE_W = 12;
    localparam int WD_W    = 3;
    localparam int SUM_W   = 15;
    localparam int CENT_W  = 8;
    localparam int YR100_W = 7;

    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd16383;

    // y / 100 as (y * 5243) >> 19, exact for every 14-bit year
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    localparam int          DIV100_SH  = 19;
    localparam int          PROD100_W  = YEAR_W + 13;

    // s / 7 as (s * 37450) >> 18, exact for every 15-bit sum
    localparam logic [15:0] DIV7_MUL = 16'd37450;
    localparam int          DIV7_SH  = 18;
    localparam int          PROD7_W  = SUM_W + 16;

    localparam logic [MON_W-1:0] MON_FEB = 4'd2;
    localparam logic [MON_W-1:0] MON_DEC = 4'd12;

    localparam logic [WD_W-1:0] WD_FRI = 3'd5;
    localparam logic [WD_W-1:0] WD_SAT = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_CENT,
        ST_SUM,
        ST_MUL7,
        ST_WDAY,
        ST_SKIP_HEAD,
        ST_COUNT,
        ST_SKIP_TAIL,
        ST_FIN
    } bdda_state_t;

    typedef struct packed {
        logic load;
        logic div;
        logic cent;
        logic sum;
        logic mul7;
        logic wday;
        logic step;
        logic count;
        logic finish;
    } bdda_cmd_t;

    typedef struct packed {
        logic weekend;
        logic left_zero;
        logic err;
        logic out_free;
    } bdda_status_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // floor(31 * mm / 12) for the shifted month
    function automatic logic [DAY_W-1:0] month_offset(input logic [MON_W-1:0] mm);
        logic [DAY_W-1:0] off;
        case (mm)
            4'd1:    off = 5'd2;
            4'd2:    off = 5'd5;
            4'd3:    off = 5'd7;
            4'd4:    off = 5'd10;
            4'd5:    off = 5'd12;
            4'd6:    off = 5'd15;
            4'd7:    off = 5'd18;
            4'd8:    off = 5'd20;
            4'd9:    off = 5'd23;
            4'd10:   off = 5'd25;
            4'd11:   off = 5'd28;
            4'd12:   off = 5'd31;
            default: off = 5'd0;
        endcase
        return off;
    endfunction

endpackage

### sv/bdda_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdda_ctrl - sequencing state machine
// Steps the datapath through weekday setup, the head weekend skip, the
// working-day count and the tail weekend skip, then hands off the result.
// ----------------------------------------------------------------------------
module bdda_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  bdda_pkg::bdda_status_t status,
    output bdda_pkg::bdda_cmd_t   cmd
);
    import bdda_pkg::*;

    bdda_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = ST_CENT;
            end
            ST_CENT:
            begin
                cmd.cent   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_MUL7;
            end
            ST_MUL7:
            begin
                cmd.mul7   = 1'b1;
                state_next = ST_WDAY;
            end
            ST_WDAY:
            begin
                cmd.wday   = 1'b1;
                state_next = ST_SKIP_HEAD;
            end
            ST_SKIP_HEAD:
            begin
                if (status.err)
                begin
                    state_next = ST_FIN;
                end
                else if (status.weekend)
                begin
                    cmd.step = 1'b1;
                end
                else
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                if (status.err)
                begin
                    state_next = ST_FIN;
                end
                else if (status.left_zero)
                begin
                    state_next = ST_SKIP_TAIL;
                end
                else
                begin
                    cmd.step  = 1'b1;
                    cmd.count = 1'b1;
                end
            end
            ST_SKIP_TAIL:
            begin
                if (status.err)
                begin
                    state_next = ST_FIN;
                end
                else if (status.weekend)
                begin
                    cmd.step = 1'b1;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // hold until the output register can take the word
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/bdda_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdda_dpath - date datapath
// Holds the running date, weekday, remaining leave and leap-year counters,
// the weekday setup arithmetic and the output register.
// ----------------------------------------------------------------------------
module bdda_dpath #(
    parameter int MAX_LEAVE_DAYS = 4095
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [bdda_pkg::DAY_W-1:0]    start_day,
    input  logic [bdda_pkg::MON_W-1:0]    start_month,
    input  logic [bdda_pkg::YEAR_W-1:0]   start_year,
    input  logic [bdda_pkg::LEAVE_W-1:0]  leave_days,
    input  bdda_pkg::bdda_cmd_t           cmd,
    output bdda_pkg::bdda_status_t        status,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bdda_pkg::DAY_W-1:0]    return_day,
    output logic [bdda_pkg::MON_W-1:0]    return_month,
    output logic [bdda_pkg::YEAR_W-1:0]   return_year,
    output logic [bdda_pkg::WD_W-1:0]     return_weekday,
    output logic                          date_invalid
);
    import bdda_pkg::*;

    localparam int LW = $clog2(MAX_LEAVE_DAYS + 1);
    localparam int CW = (LW > LEAVE_W) ? LW : LEAVE_W;

    logic [DAY_W-1:0]     day_reg, day_next;
    logic [MON_W-1:0]     mon_reg, mon_next;
    logic [YEAR_W-1:0]    year_reg, year_next;
    logic [WD_W-1:0]      wd_reg, wd_next;
    logic [LW-1:0]        left_reg, left_next;
    logic                 err_reg, err_next;
    logic [YR100_W-1:0]   yr100_reg, yr100_next;
    logic [1:0]           cent4_reg, cent4_next;
    logic [CENT_W-1:0]    cent_reg, cent_next;
    logic [PROD100_W-1:0] prod100_reg, prod100_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [PROD7_W-1:0]   prod7_reg, prod7_next;

    logic                 out_valid_reg, out_valid_next;
    logic [DAY_W-1:0]     oday_reg, oday_next;
    logic [MON_W-1:0]     omon_reg, omon_next;
    logic [YEAR_W-1:0]    oyear_reg, oyear_next;
    logic [WD_W-1:0]      owd_reg, owd_next;
    logic                 oinv_reg, oinv_next;

    logic [CW-1:0]        leave_ext;
    logic [CW-1:0]        max_ext;
    logic                 leap;
    logic                 weekend;
    logic [DAY_W-1:0]     mlen;
    logic [CENT_W-1:0]    q100;
    logic [YEAR_W-1:0]    r100_full;
    logic                 shift_a;
    logic [MON_W-1:0]     mm;
    logic [YEAR_W-1:0]    yy;
    logic [CENT_W-1:0]    qyy;
    logic [12:0]          q7;
    logic [SUM_W-1:0]     r7_full;
    logic                 start_bad;

    assign leap    = (yr100_reg == '0) ? (cent4_reg == 2'd0) : (year_reg[1:0] == 2'd0);
    assign weekend = (wd_reg == WD_FRI) || (wd_reg == WD_SAT);
    assign mlen    = month_len(mon_reg, leap);

    assign leave_ext = CW'(leave_days);
    assign max_ext   = CW'(MAX_LEAVE_DAYS);

    assign q100      = prod100_reg[DIV100_SH +: CENT_W];
    assign r100_full = year_reg - YEAR_W'(q100) * 14'd100;

    assign shift_a = (mon_reg <= MON_FEB);
    assign mm      = shift_a ? mon_reg + 4'd10 : mon_reg - 4'd2;
    assign yy      = year_reg - YEAR_W'(shift_a);
    assign qyy     = (shift_a && (yr100_reg == '0)) ? cent_reg - 8'd1 : cent_reg;

    assign q7      = prod7_reg[DIV7_SH +: 13];
    assign r7_full = sum_reg - SUM_W'(q7) * 15'd7;

    assign start_bad = (year_reg == '0) || (mon_reg == '0) || (mon_reg > MON_DEC)
                       || (day_reg == '0) || (day_reg > mlen);

    always_comb
    begin
        day_next       = day_reg;
        mon_next       = mon_reg;
        year_next      = year_reg;
        wd_next        = wd_reg;
        left_next      = left_reg;
        err_next       = err_reg;
        yr100_next     = yr100_reg;
        cent4_next     = cent4_reg;
        cent_next      = cent_reg;
        prod100_next   = prod100_reg;
        sum_next       = sum_reg;
        prod7_next     = prod7_reg;
        out_valid_next = out_valid_reg;
        oday_next      = oday_reg;
        omon_next      = omon_reg;
        oyear_next     = oyear_reg;
        owd_next       = owd_reg;
        oinv_next      = oinv_reg;

        if (cmd.load)
        begin
            day_next  = start_day;
            mon_next  = start_month;
            year_next = start_year;
            left_next = LW'((leave_ext > max_ext) ? max_ext : leave_ext);
            err_next  = 1'b0;
        end

        if (cmd.div)
        begin
            prod100_next = PROD100_W'(year_reg) * PROD100_W'(DIV100_MUL);
        end

        if (cmd.cent)
        begin
            cent_next  = q100;
            yr100_next = r100_full[YR100_W-1:0];
            cent4_next = q100[1:0];
        end

        if (cmd.sum)
        begin
            err_next = start_bad;
            sum_next = SUM_W'(day_reg) + SUM_W'(yy) + SUM_W'(yy >> 2)
                       + SUM_W'(qyy >> 2) + SUM_W'(month_offset(mm)) - SUM_W'(qyy);
        end

        if (cmd.mul7)
        begin
            prod7_next = PROD7_W'(sum_reg) * PROD7_W'(DIV7_MUL);
        end

        if (cmd.wday)
        begin
            wd_next = r7_full[WD_W-1:0];
        end

        if (cmd.step)
        begin
            wd_next = (wd_reg == WD_SAT) ? '0 : wd_reg + 3'd1;
            if (day_reg >= mlen)
            begin
                day_next = 5'd1;
                if (mon_reg >= MON_DEC)
                begin
                    mon_next = 4'd1;
                    if (year_reg == YEAR_MAX)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        year_next = year_reg + 14'd1;
                        // advance the century counters with the year
                        if (yr100_reg == 7'd99)
                        begin
                            yr100_next = '0;
                            cent4_next = cent4_reg + 2'd1;
                        end
                        else
                        begin
                            yr100_next = yr100_reg + 7'd1;
                        end
                    end
                end
                else
                begin
                    mon_next = mon_reg + 4'd1;
                end
            end
            else
            begin
                day_next = day_reg + 5'd1;
            end
            if (cmd.count && !weekend)
            begin
                left_next = left_reg - LW'(1);
            end
        end

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            oinv_next      = err_reg;
            oday_next      = err_reg ? '0 : day_reg;
            omon_next      = err_reg ? '0 : mon_reg;
            oyear_next     = err_reg ? '0 : year_reg;
            owd_next       = err_reg ? '0 : wd_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            err_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            err_reg       <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        day_reg     <= day_next;
        mon_reg     <= mon_next;
        year_reg    <= year_next;
        wd_reg      <= wd_next;
        left_reg    <= left_next;
        yr100_reg   <= yr100_next;
        cent4_reg   <= cent4_next;
        cent_reg    <= cent_next;
        prod100_reg <= prod100_next;
        sum_reg     <= sum_next;
        prod7_reg   <= prod7_next;
        oday_reg    <= oday_next;
        omon_reg    <= omon_next;
        oyear_reg   <= oyear_next;
        owd_reg     <= owd_next;
        oinv_reg    <= oinv_next;
    end

    assign status.weekend   = weekend;
    assign status.left_zero = (left_reg == '0);
    assign status.err       = err_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid      = out_valid_reg;
    assign return_day     = oday_reg;
    assign return_month   = omon_reg;
    assign return_year    = oyear_reg;
    assign return_weekday = owd_reg;
    assign date_invalid   = oinv_reg;

endmodule

### sv/business_day_date_adder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// business_day_date_adder - working-day date adder
// Adds a count of working days (Friday and Saturday off) to a Gregorian date
// and returns the return-to-work date with its weekday.
// ----------------------------------------------------------------------------
//  word     | handshake             | fields
//  ---------+-----------------------+---------------------------------------
//  in       | in_valid / in_stall   | start_day, start_month, start_year,
//           |                       | leave_days
//  out      | out_valid / out_stall | return_day, return_month, return_year,
//           |                       | return_weekday, date_invalid
//
//  An item steps through the accepting state, the weekday setup states DIV, CENT,
//  SUM, MUL7 and WDAY (two constant multiplies), the date stepper walking one
//  calendar day per step through the head skip, count and tail skip phases, and
//  the load of the output register. Invalid dates finish early.
//  in_stall is high from acceptance until the result is in the output register.
//  A result held by out_stall blocks only the final hand-off; a new word is
//  taken while it waits. Reset clears the controller and the output valid.
// ----------------------------------------------------------------------------
module business_day_date_adder #(
    parameter int MAX_LEAVE_DAYS = 4095
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bdda_pkg::DAY_W-1:0]    start_day,
    input  logic [bdda_pkg::MON_W-1:0]    start_month,
    input  logic [bdda_pkg::YEAR_W-1:0]   start_year,
    input  logic [bdda_pkg::LEAVE_W-1:0]  leave_days,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bdda_pkg::DAY_W-1:0]    return_day,
    output logic [bdda_pkg::MON_W-1:0]    return_month,
    output logic [bdda_pkg::YEAR_W-1:0]   return_year,
    output logic [bdda_pkg::WD_W-1:0]     return_weekday,
    output logic                          date_invalid
);
    import bdda_pkg::*;

    bdda_cmd_t    cmd;
    bdda_status_t status;

    bdda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    bdda_dpath #(
        .MAX_LEAVE_DAYS (MAX_LEAVE_DAYS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .start_day      (start_day),
        .start_month    (start_month),
        .start_year     (start_year),
        .leave_days     (leave_days),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .return_day     (return_day),
        .return_month   (return_month),
        .return_year    (return_year),
        .return_weekday (return_weekday),
        .date_invalid   (date_invalid)
    );

`ifndef SYNTHESIS
    // an accepted word keeps the input side busy while it is worked on
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again straight after an accept");

    a_invalid_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && date_invalid |->
            return_day == '0 && return_month == '0 && return_year == '0
            && return_weekday == '0)
        else $error("invalid result carries a non-zero date");

    a_return_workday: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !date_invalid |->
            return_weekday != WD_FRI && return_weekday != WD_SAT
            && return_weekday != 3'd7)
        else $error("return date is not a working day");

    a_return_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !date_invalid |->
            return_day != '0 && return_month != '0 && return_month <= MON_DEC
            && return_year != '0)
        else $error("return date out of range");
`endif

endmodule

### test/tb_business_day_date_adder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_business_day_date_adder - self-checking bench for the working-day adder
// Drives start dates and leave counts through the valid/stall input channel,
// predicts the return-to-work date and weekday in the bench, and compares
// every returned word field by field, in order, with random idling on both
// channels.
// ----------------------------------------------------------------------------

localparam int unsigned LEAVE_CAP = 4095;

typedef struct {
    int unsigned day;
    int unsigned month;
    int unsigned year;
    int unsigned weekday;
    bit          invalid;
} return_date_t;

class return_date_book;

    return_date_t awaited_returns[$];
    int unsigned  requests_noted;
    int unsigned  returns_checked;
    int unsigned  invalid_returns;
    int unsigned  longest_leave;
    int unsigned  mismatches;

    static function bit has_leap_day(int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    static function int unsigned month_days(int unsigned y, int unsigned m);
        if (m < 1 || m > bdda_pkg::MON_DEC)
            return 0;
        if (m == bdda_pkg::MON_FEB)
            return has_leap_day(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    // shifted-month weekday, 0 is Sunday
    static function int unsigned weekday_from(int unsigned d, int unsigned m,
                                              int unsigned y);
        int unsigned a;
        int unsigned yy;
        int unsigned mm;
        a  = (14 - m) / 12;
        yy = y - a;
        mm = m + 12 * a - 2;
        return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
    endfunction

    static function bit off_day(int unsigned wd);
        return wd == bdda_pkg::WD_FRI || wd == bdda_pkg::WD_SAT;
    endfunction

    // advance one calendar day; drop out on year overflow
    static function bit step_day(inout int unsigned d, inout int unsigned m,
                                 inout int unsigned y, inout int unsigned wd);
        wd = (wd + 1) % 7;
        if (d >= month_days(y, m)) begin
            d = 1;
            if (m >= bdda_pkg::MON_DEC) begin
                m = 1;
                if (y >= bdda_pkg::YEAR_MAX)
                    return 1'b0;
                y = y + 1;
            end
            else
            begin
                m = m + 1;
            end
        end
        else
        begin
            d = d + 1;
        end
        return 1'b1;
    endfunction

    static function return_date_t predict_return(int unsigned d, int unsigned m,
                                                 int unsigned y, int unsigned leave);
        return_date_t r;
        int unsigned  wd;
        int unsigned  left;
        bit           ok;
        left = (leave > LEAVE_CAP) ? LEAVE_CAP : leave;
        ok   = (y != 0) && (m >= 1) && (m <= bdda_pkg::MON_DEC) && (d != 0)
               && (d <= month_days(y, m));
        wd   = 0;
        if (ok)
        begin
            wd = weekday_from(d, m, y);
            while (ok && off_day(wd))
                ok = step_day(d, m, y, wd);
            while (ok && left != 0)
            begin
                if (!off_day(wd))
                    left = left - 1;
                ok = step_day(d, m, y, wd);
            end
            while (ok && off_day(wd))
                ok = step_day(d, m, y, wd);
        end
        r.day     = ok ? d : 0;
        r.month   = ok ? m : 0;
        r.year    = ok ? y : 0;
        r.weekday = ok ? wd : 0;
        r.invalid = !ok;
        return r;
    endfunction

    function void note_leave_request(int unsigned d, int unsigned m, int unsigned y,
                                     int unsigned leave);
        awaited_returns.push_back(predict_return(d, m, y, leave));
        requests_noted++;
        if (leave > longest_leave)
            longest_leave = leave;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function void check_return_date(int unsigned d, int unsigned m, int unsigned y,
                                    int unsigned wd, bit inv);
        return_date_t want;
        if (awaited_returns.size() == 0)
        begin
            $error("return word with no request waiting: %0d-%0d-%0d", y, m, d);
            mismatches++;
            return;
        end
        want = awaited_returns.pop_front();
        compare_field("return_day", want.day, d);
        compare_field("return_month", want.month, m);
        compare_field("return_year", want.year, y);
        compare_field("return_weekday", want.weekday, wd);
        compare_field("date_invalid", want.invalid, inv);
        returns_checked++;
        if (want.invalid)
            invalid_returns++;
    endfunction

    function int unsigned awaited_count();
        return awaited_returns.size();
    endfunction

endclass

module tb_business_day_date_adder;

    import bdda_pkg::*;

    localparam int RANDOM_ITEMS = 100;
    localparam int STALL_LIMIT  = 40000;
    localparam int DRAIN_CYCLES = 50;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [DAY_W-1:0]     start_day   = '0;
    logic [MON_W-1:0]     start_month = '0;
    logic [YEAR_W-1:0]    start_year  = '0;
    logic [LEAVE_W-1:0]   leave_days  = '0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic [DAY_W-1:0]     return_day;
    logic [MON_W-1:0]     return_month;
    logic [YEAR_W-1:0]    return_year;
    logic [WD_W-1:0]      return_weekday;
    logic                 date_invalid;

    return_date_book      book;
    bit                   quiet_stretch = 1'b0;
    int                   stall_run     = 0;
    int                   idle_cycles   = 0;

    business_day_date_adder #(
        .MAX_LEAVE_DAYS (LEAVE_CAP)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .start_day      (start_day),
        .start_month    (start_month),
        .start_year     (start_year),
        .leave_days     (leave_days),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .return_day     (return_day),
        .return_month   (return_month),
        .return_year    (return_year),
        .return_weekday (return_weekday),
        .date_invalid   (date_invalid)
    );

    always #5 clk = ~clk;

    // return side: short random stalls, now and then a long one
    always @(posedge clk)
    begin
        if (stall_run != 0)
        begin
            out_stall <= 1'b1;
            stall_run <= stall_run - 1;
        end
        else if (!quiet_stretch && $urandom_range(99, 0) < 2)
        begin
            out_stall <= 1'b1;
            stall_run <= ($urandom_range(19, 0) == 0) ? $urandom_range(40, 10)
                                                      : $urandom_range(3, 0);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // note accepted requests, check accepted returns, watch for a hang
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                book.note_leave_request(start_day, start_month, start_year, leave_days);
            if (out_valid && !out_stall)
                book.check_return_date(return_day, return_month, return_year,
                                       return_weekday, date_invalid);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $error("no word moved for %0d cycles", STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // present one request and hold it until taken; entered at a clock edge
    task automatic send_request(input int unsigned d, input int unsigned m,
                                input int unsigned y, input int unsigned leave);
        if (!quiet_stretch && $urandom_range(99, 0) < 7)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        start_day   <= d[DAY_W-1:0];
        start_month <= m[MON_W-1:0];
        start_year  <= y[YEAR_W-1:0];
        leave_days  <= leave[LEAVE_W-1:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // hold off until every awaited return has come back
    task automatic drain_returns();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (book.awaited_count() != 0);
    endtask

    initial
    begin
        int unsigned d;
        int unsigned m;
        int unsigned y;
        int unsigned leave;
        int unsigned pick;

        book = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, leap rules, bad dates, weekend starts, overflow
        send_request(1, 1, 1, 0);
        send_request(31, 12, 9999, 0);
        send_request(29, 2, 2024, 10);
        send_request(29, 2, 2023, 3);
        send_request(29, 2, 1900, 3);
        send_request(29, 2, 2000, 3);
        send_request(0, 5, 2010, 7);
        send_request(15, 0, 2010, 7);
        send_request(15, 15, 2010, 7);
        send_request(15, 6, 0, 7);
        send_request(31, 4, 2021, 2);
        send_request(31, 15, 16383, 4095);
        send_request(1, 3, 2024, 0);
        send_request(2, 3, 2024, 0);
        send_request(1, 3, 2024, 1);
        send_request(30, 4, 2021, 5);
        send_request(31, 12, 2021, 3);
        send_request(31, 12, 16383, 0);
        send_request(31, 12, 16383, 1);
        send_request(1, 1, 16383, 4095);
        send_request(1, 1, 2000, 4095);
        send_request(28, 2, 2100, 20);
        drain_returns();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            quiet_stretch = (i >= 30 && i < 55);
            if (i == 60)
                drain_returns();
            pick = $urandom_range(99, 0);
            if (pick < 12)
            begin
                // noise: any bit pattern, some of them invalid dates
                d = $urandom_range(31, 0);
                m = $urandom_range(15, 0);
                y = $urandom_range(16383, 0);
            end
            else
            begin
                if (pick < 20)
                begin
                    y = $urandom_range(16383, 16382);
                    m = $urandom_range(12, 10);
                end
                else
                begin
                    y = (pick < 45) ? $urandom_range(16383, 1) : $urandom_range(9999, 1);
                    m = $urandom_range(12, 1);
                end
                d = $urandom_range(book.month_days(y, m), 1);
            end
            pick = $urandom_range(99, 0);
            if (pick < 80)
                leave = $urandom_range(40, 0);
            else if (pick < 95)
                leave = $urandom_range(700, 41);
            else
                leave = $urandom_range(4095, 701);
            send_request(d, m, y, leave);
        end
        quiet_stretch = 1'b0;

        drain_returns();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d date requests, leave up to %0d days; compared %0d returns,",
                 book.requests_noted, book.longest_leave, book.returns_checked);
        $display("%0d of them flagged as bad start dates or year overflow.",
                 book.invalid_returns);
        if (book.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
sv/bdda_pkg.sv
sv/bdda_ctrl.sv
sv/bdda_dpath.sv
sv/business_day_date_adder.sv
test/tb_business_day_date_adder.sv
